>>> sv/hct_pkg.sv
package hct_pkg;

	// Default periods, in machine cycles.
	localparam int unsigned DIV_PERIOD_DEF  = 256;
	localparam int unsigned PERIOD_SEL0_DEF = 1024;
	localparam int unsigned PERIOD_SEL1_DEF = 16;
	localparam int unsigned PERIOD_SEL2_DEF = 64;
	localparam int unsigned PERIOD_SEL3_DEF = 256;

	// Accumulator widths: the divider holds up to 255 + 255, the counter up to 2047 + 255.
	localparam int unsigned DIV_ACC_W = 9;
	localparam int unsigned CNT_ACC_W = 12;
	localparam int unsigned CNT_TICKS_W = 11;

	// Register addresses on the bus.
	localparam logic [15:0] ADDR_DIV  = 16'hFF04;
	localparam logic [15:0] ADDR_TIMA = 16'hFF05;
	localparam logic [15:0] ADDR_TMA  = 16'hFF06;
	localparam logic [15:0] ADDR_TAC  = 16'hFF07;

	localparam logic [7:0] BYTE_UNMAPPED = 8'hFF;
	localparam int unsigned TAC_ENABLE_BIT = 2;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_WRITE = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} hct_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pending;
	} hct_sts_t;

	// Counter period for a TAC select code.
	function automatic logic [CNT_ACC_W-1:0] period_of(
		input logic [1:0] sel,
		input logic [CNT_ACC_W-1:0] p0,
		input logic [CNT_ACC_W-1:0] p1,
		input logic [CNT_ACC_W-1:0] p2,
		input logic [CNT_ACC_W-1:0] p3
	);
		logic [CNT_ACC_W-1:0] p;
		unique case (sel)
			2'd0: p = p0;
			2'd1: p = p1;
			2'd2: p = p2;
			default: p = p3;
		endcase
		return p;
	endfunction

endpackage

>>> sv/hct_ctrl.sv
module hct_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  hct_pkg::hct_sts_t  sts,
	output hct_pkg::hct_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;

	assign cmd.load   = (state_q == ST_IDLE) && in_valid;
	assign cmd.step   = (state_q == ST_RUN);
	assign cmd.finish = (state_q == ST_RUN) && !sts.pending && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/hct_dp.sv
module hct_dp #(
	parameter int unsigned DIV_PERIOD  = hct_pkg::DIV_PERIOD_DEF,
	parameter int unsigned PERIOD_SEL0 = hct_pkg::PERIOD_SEL0_DEF,
	parameter int unsigned PERIOD_SEL1 = hct_pkg::PERIOD_SEL1_DEF,
	parameter int unsigned PERIOD_SEL2 = hct_pkg::PERIOD_SEL2_DEF,
	parameter int unsigned PERIOD_SEL3 = hct_pkg::PERIOD_SEL3_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hct_pkg::hct_cmd_t  cmd,
	output hct_pkg::hct_sts_t  sts,
	input  logic [1:0]         func,
	input  logic [7:0]         cycle_count,
	input  logic [15:0]        bus_address,
	input  logic [7:0]         write_data,
	output logic [7:0]         read_data,
	output logic               timer_irq
);

	localparam int unsigned DW = hct_pkg::DIV_ACC_W;
	localparam int unsigned CW = hct_pkg::CNT_ACC_W;
	localparam int unsigned TW = hct_pkg::CNT_TICKS_W;
	localparam logic [DW-1:0] DIV_P = DW'(DIV_PERIOD);

	// Latched item.
	hct_pkg::func_t func_q;
	logic [15:0]    addr_q;
	logic [7:0]     data_q;

	// Working accumulators and the overflow flag of the current tick.
	logic [DW-1:0]  div_acc_q;
	logic [CW-1:0]  cnt_acc_q;
	logic           irq_q;

	// Timer registers.
	logic [7:0]     div_ticks_q;
	logic [7:0]     div_value_q;
	logic [TW-1:0]  cnt_ticks_q;
	logic [7:0]     tima_q;
	logic [7:0]     tma_q;
	logic [7:0]     tac_q;

	// Result register.
	logic [7:0]     read_data_q;
	logic           timer_irq_q;

	logic           is_tick;
	logic           div_go;
	logic           cnt_go;
	logic [CW-1:0]  period;
	logic [7:0]     rd_byte;

	assign period = hct_pkg::period_of(tac_q[1:0], CW'(PERIOD_SEL0), CW'(PERIOD_SEL1),
		CW'(PERIOD_SEL2), CW'(PERIOD_SEL3));

	assign is_tick     = (func_q == hct_pkg::FUNC_TICK);
	assign div_go      = is_tick && (div_acc_q >= DIV_P);
	assign cnt_go      = is_tick && tac_q[hct_pkg::TAC_ENABLE_BIT] && (cnt_acc_q >= period);
	assign sts.pending = div_go || cnt_go;

	always_comb begin
		priority if (addr_q == hct_pkg::ADDR_DIV) begin
			rd_byte = div_value_q;
		end else if (addr_q == hct_pkg::ADDR_TIMA) begin
			rd_byte = tima_q;
		end else if (addr_q == hct_pkg::ADDR_TMA) begin
			rd_byte = tma_q;
		end else if (addr_q == hct_pkg::ADDR_TAC) begin
			rd_byte = tac_q;
		end else begin
			rd_byte = hct_pkg::BYTE_UNMAPPED;
		end
	end

	// Item latch, accumulators and result byte carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= hct_pkg::func_t'(func);
			addr_q    <= bus_address;
			data_q    <= write_data;
			div_acc_q <= {1'b0, div_ticks_q} + DW'(cycle_count);
			cnt_acc_q <= {1'b0, cnt_ticks_q} + CW'(cycle_count);
		end else if (cmd.step) begin
			if (div_go) begin
				div_acc_q <= div_acc_q - DIV_P;
			end
			if (cnt_go) begin
				cnt_acc_q <= cnt_acc_q - period;
			end
		end
		if (cmd.finish) begin
			read_data_q <= (func_q == hct_pkg::FUNC_READ) ? rd_byte : hct_pkg::BYTE_UNMAPPED;
			timer_irq_q <= is_tick && irq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q       <= 1'b0;
			div_ticks_q <= '0;
			div_value_q <= '0;
			cnt_ticks_q <= '0;
			tima_q      <= '0;
			tma_q       <= '0;
			tac_q       <= '0;
		end else if (cmd.load) begin
			irq_q <= 1'b0;
		end else if (cmd.finish) begin
			if (is_tick) begin
				div_ticks_q <= div_acc_q[7:0];
				if (tac_q[hct_pkg::TAC_ENABLE_BIT]) begin
					cnt_ticks_q <= cnt_acc_q[TW-1:0];
				end
			end else if (func_q == hct_pkg::FUNC_WRITE) begin
				unique case (addr_q)
					hct_pkg::ADDR_DIV: begin
						div_value_q <= '0;
						div_ticks_q <= '0;
					end
					hct_pkg::ADDR_TIMA: begin
						tima_q <= data_q;
					end
					hct_pkg::ADDR_TMA: begin
						tma_q <= data_q;
					end
					hct_pkg::ADDR_TAC: begin
						tac_q <= data_q;
					end
					default: begin
						// Writes outside the register window are dropped.
					end
				endcase
			end
		end else if (cmd.step) begin
			if (div_go) begin
				div_value_q <= div_value_q + 8'd1;
			end
			if (cnt_go) begin
				// An increment past 0xFF reloads from TMA and flags the interrupt.
				if (tima_q == 8'hFF) begin
					tima_q <= tma_q;
					irq_q  <= 1'b1;
				end else begin
					tima_q <= tima_q + 8'd1;
				end
			end
		end
	end

	assign read_data = read_data_q;
	assign timer_irq = timer_irq_q;

endmodule

>>> sv/handheld_console_timer.sv
// Console timer with a free-running divider (DIV), a counter (TIMA), a reload value
// (TMA) and a control byte (TAC), mapped at 0xFF04 to 0xFF07. Every accepted item
// gives exactly one result item. The item is loaded on acceptance; a tick then
// iterates while divider or counter steps remain, the datapath taking one divider
// step and one counter step per clock, while a bus read or write or an unused
// function code takes no steps. The result then enters the output register once
// that register is free. Just after the period is shortened, the counter
// accumulator may hold up to 1023 + 255 machine cycles for the first tick to drain.
// The next item is accepted as soon as the current one has entered the output
// register, even while that result is still stalled downstream.
module handheld_console_timer #(
	parameter int unsigned DIV_PERIOD  = hct_pkg::DIV_PERIOD_DEF,
	parameter int unsigned PERIOD_SEL0 = hct_pkg::PERIOD_SEL0_DEF,
	parameter int unsigned PERIOD_SEL1 = hct_pkg::PERIOD_SEL1_DEF,
	parameter int unsigned PERIOD_SEL2 = hct_pkg::PERIOD_SEL2_DEF,
	parameter int unsigned PERIOD_SEL3 = hct_pkg::PERIOD_SEL3_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  cycle_count,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        timer_irq
);

	hct_pkg::hct_cmd_t cmd;
	hct_pkg::hct_sts_t sts;

	// The controller sequences each item: load, iterate while steps remain, then
	// commit the item into the timer registers and the output register together.
	hct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the timer registers, the working accumulators and the
	// result register.
	hct_dp #(
		.DIV_PERIOD  (DIV_PERIOD),
		.PERIOD_SEL0 (PERIOD_SEL0),
		.PERIOD_SEL1 (PERIOD_SEL1),
		.PERIOD_SEL2 (PERIOD_SEL2),
		.PERIOD_SEL3 (PERIOD_SEL3)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.cycle_count (cycle_count),
		.bus_address (bus_address),
		.write_data  (write_data),
		.read_data   (read_data),
		.timer_irq   (timer_irq)
	);

endmodule

>>> tb/timer_checker.sv
`timescale 1ns / 1ps

module timer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  cycle_count,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  read_data,
	input  logic        timer_irq,
	output int          fails,
	output int          pending,
	output int          results_seen,
	output int          irqs_seen
);

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} timer_result_t;

	timer_result_t expected_q[$];

	// Shadow copy of the timer registers and its divider and counter accumulators.
	logic [7:0]  div_acc;
	logic [7:0]  div_count;
	logic [10:0] tima_acc;
	logic [7:0]  tima;
	logic [7:0]  tma;
	logic [7:0]  tac;
	int          mismatches;
	int          result_count;
	int          irq_count;

	always @(posedge clk or negedge arst_n) begin
		int            acc;
		int            period;
		timer_result_t want;
		timer_result_t oldest;
		if (!arst_n) begin
			div_acc = '0;
			div_count = '0;
			tima_acc = '0;
			tima = '0;
			tma = '0;
			tac = '0;
			expected_q.delete();
			mismatches = 0;
			result_count = 0;
			irq_count = 0;
		end else begin
			// Predict first: a result never leaves in the cycle its item enters.
			if (in_valid && !in_stall) begin
				want.read_data = hct_pkg::BYTE_UNMAPPED;
				want.timer_irq = 1'b0;
				case (hct_pkg::func_t'(func))
					hct_pkg::FUNC_TICK: begin
						acc = div_acc + cycle_count;
						while (acc >= hct_pkg::DIV_PERIOD_DEF) begin
							acc -= hct_pkg::DIV_PERIOD_DEF;
							div_count++;
						end
						div_acc = acc[7:0];
						// A disabled timer holds its accumulator as it stands.
						if (tac[hct_pkg::TAC_ENABLE_BIT]) begin
							case (tac[1:0])
								2'd0: period = hct_pkg::PERIOD_SEL0_DEF;
								2'd1: period = hct_pkg::PERIOD_SEL1_DEF;
								2'd2: period = hct_pkg::PERIOD_SEL2_DEF;
								default: period = hct_pkg::PERIOD_SEL3_DEF;
							endcase
							acc = tima_acc + cycle_count;
							while (acc >= period) begin
								acc -= period;
								tima++;
								if (tima == 8'h00) begin
									tima = tma;
									want.timer_irq = 1'b1;
								end
							end
							tima_acc = acc[10:0];
						end
					end
					hct_pkg::FUNC_READ: begin
						case (bus_address)
							hct_pkg::ADDR_DIV:  want.read_data = div_count;
							hct_pkg::ADDR_TIMA: want.read_data = tima;
							hct_pkg::ADDR_TMA:  want.read_data = tma;
							hct_pkg::ADDR_TAC:  want.read_data = tac;
							default:            want.read_data = hct_pkg::BYTE_UNMAPPED;
						endcase
					end
					hct_pkg::FUNC_WRITE: begin
						case (bus_address)
							hct_pkg::ADDR_DIV: begin
								div_count = '0;
								div_acc = '0;
							end
							hct_pkg::ADDR_TIMA: tima = write_data;
							hct_pkg::ADDR_TMA:  tma = write_data;
							hct_pkg::ADDR_TAC:  tac = write_data;
							default: ;
						endcase
					end
					default: ;
				endcase
				expected_q.push_back(want);
			end

			if (out_valid && !out_stall) begin
				result_count++;
				if (timer_irq === 1'b1)
					irq_count++;
				if (expected_q.size() == 0) begin
					$error("unexpected result: read_data=%h timer_irq=%b", read_data, timer_irq);
					mismatches++;
				end else begin
					oldest = expected_q.pop_front();
					if (read_data !== oldest.read_data) begin
						$error("read_data: expected %h, got %h", oldest.read_data, read_data);
						mismatches++;
					end
					if (timer_irq !== oldest.timer_irq) begin
						$error("timer_irq: expected %b, got %b", oldest.timer_irq, timer_irq);
						mismatches++;
					end
				end
			end
		end
		fails <= mismatches;
		pending <= expected_q.size();
		results_seen <= result_count;
		irqs_seen <= irq_count;
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  func;
	logic [7:0]  cycle_count;
	logic [15:0] bus_address;
	logic [7:0]  write_data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_data;
	logic        timer_irq;

	int fails;
	int pending;
	int results_seen;
	int irqs_seen;

	// When this is low, neither side starts new gaps or stalls.
	logic idling;
	int   stall_left;
	int   func_count[4];

	handheld_console_timer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.cycle_count(cycle_count),
		.bus_address(bus_address),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.timer_irq  (timer_irq)
	);

	timer_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.cycle_count (cycle_count),
		.bus_address (bus_address),
		.write_data  (write_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.timer_irq   (timer_irq),
		.fails       (fails),
		.pending     (pending),
		.results_seen(results_seen),
		.irqs_seen   (irqs_seen)
	);

	// The clock has a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// The result side stalls in bursts. A burst starts on roughly one cycle in six
	// while idling is enabled, so stalls land on every phase of a tick.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left <= 0;
			out_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 7);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Presents one item and returns at the edge where it is accepted. A gap, when one is
	// taken, lowers valid first; otherwise valid stays high from the previous item, so it
	// is never lowered and raised in the same step.
	task automatic issue_op(input hct_pkg::func_t f, input logic [7:0] cyc,
			input logic [15:0] addr, input logic [7:0] data);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		cycle_count <= cyc;
		bus_address <= addr;
		write_data <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		func_count[f]++;
	endtask

	// Mostly one of the four timer registers, sometimes any address at all.
	function automatic logic [15:0] pick_address();
		if ($urandom_range(0, 99) < 85)
			return hct_pkg::ADDR_DIV + 16'($urandom_range(0, 3));
		return 16'($urandom);
	endfunction

	// Tick lengths lean toward the extremes of the field.
	function automatic logic [7:0] pick_cycles();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	initial begin
		int          r;
		logic [15:0] addr;
		logic [7:0]  data;

		arst_n = 1'b0;
		in_valid = 1'b0;
		func = hct_pkg::FUNC_TICK;
		cycle_count = '0;
		bus_address = '0;
		write_data = '0;
		idling = 1'b0;
		foreach (func_count[i])
			func_count[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with idling on so that the handshakes are exercised early.
		idling = 1'b1;
		// Every register reads back zero after reset; unmapped reads return all ones.
		issue_op(hct_pkg::FUNC_READ, 8'h00, hct_pkg::ADDR_DIV, 8'h00);
		issue_op(hct_pkg::FUNC_READ, 8'h00, hct_pkg::ADDR_TIMA, 8'h00);
		issue_op(hct_pkg::FUNC_READ, 8'h00, hct_pkg::ADDR_TMA, 8'h00);
		issue_op(hct_pkg::FUNC_READ, 8'h00, hct_pkg::ADDR_TAC, 8'h00);
		issue_op(hct_pkg::FUNC_READ, 8'hFF, 16'h0000, 8'hFF);
		issue_op(hct_pkg::FUNC_READ, 8'h00, 16'hFFFF, 8'h00);
		// TIMA two steps short of wrapping, period select code 1, upper TAC bits set as well.
		// A full tick of 0xFF then wraps once and keeps counting from the reload value.
		issue_op(hct_pkg::FUNC_WRITE, 8'h00, hct_pkg::ADDR_TMA, 8'hA5);
		issue_op(hct_pkg::FUNC_WRITE, 8'h00, hct_pkg::ADDR_TIMA, 8'hFE);
		issue_op(hct_pkg::FUNC_WRITE, 8'h00, hct_pkg::ADDR_TAC, 8'hFD);
		issue_op(hct_pkg::FUNC_TICK, 8'hFF, 16'h0000, 8'h00);
		issue_op(hct_pkg::FUNC_READ, 8'h00, hct_pkg::ADDR_TIMA, 8'h00);
		issue_op(hct_pkg::FUNC_TICK, 8'h00, 16'hFFFF, 8'hFF);
		// A write to DIV clears it whatever the data.
		issue_op(hct_pkg::FUNC_WRITE, 8'h00, hct_pkg::ADDR_DIV, 8'hFF);
		issue_op(hct_pkg::FUNC_READ, 8'h00, hct_pkg::ADDR_DIV, 8'h00);
		// The unused function code must leave every register alone.
		issue_op(hct_pkg::FUNC_NONE, 8'hFF, hct_pkg::ADDR_TIMA, 8'h5A);
		// Writes just outside the register window are dropped.
		issue_op(hct_pkg::FUNC_WRITE, 8'h00, 16'hFF03, 8'h12);
		issue_op(hct_pkg::FUNC_WRITE, 8'h00, 16'hFF08, 8'h34);
		// With the timer disabled the counter accumulator is held, not cleared.
		issue_op(hct_pkg::FUNC_WRITE, 8'h00, hct_pkg::ADDR_TAC, 8'h03);
		issue_op(hct_pkg::FUNC_TICK, 8'd200, 16'h0000, 8'h00);
		// Build up a large accumulator at the slowest period, then switch to the
		// fastest one so the next tick drains it in many steps.
		issue_op(hct_pkg::FUNC_WRITE, 8'h00, hct_pkg::ADDR_TAC, 8'h04);
		issue_op(hct_pkg::FUNC_TICK, 8'hFF, 16'h0000, 8'h00);
		issue_op(hct_pkg::FUNC_TICK, 8'hFF, 16'h0000, 8'h00);
		issue_op(hct_pkg::FUNC_TICK, 8'hFF, 16'h0000, 8'h00);
		issue_op(hct_pkg::FUNC_WRITE, 8'h00, hct_pkg::ADDR_TAC, 8'h05);
		issue_op(hct_pkg::FUNC_TICK, 8'hFF, 16'h0000, 8'h00);
		issue_op(hct_pkg::FUNC_READ, 8'h00, hct_pkg::ADDR_TIMA, 8'h00);

		// Random part. Idling is switched off for one block in three and for the last
		// stretch of the run. Fields an item does not use still carry random values.
		for (int i = 0; i < 500; i++) begin
			idling = ((i / 64) % 3 != 2) && (i < 440);
			r = $urandom_range(0, 99);
			addr = pick_address();
			data = 8'($urandom);
			if (r < 45) begin
				issue_op(hct_pkg::FUNC_TICK, pick_cycles(), 16'($urandom), 8'($urandom));
			end else if (r < 70) begin
				issue_op(hct_pkg::FUNC_READ, 8'($urandom), addr, 8'($urandom));
			end else if (r < 95) begin
				// Keep the timer enabled most of the time and TIMA often near the wrap,
				// so that overflows and reloads happen regularly.
				if (addr == hct_pkg::ADDR_TAC && $urandom_range(0, 3) != 0)
					data[hct_pkg::TAC_ENABLE_BIT] = 1'b1;
				if (addr == hct_pkg::ADDR_TIMA && $urandom_range(0, 9) < 3)
					data = 8'hFE + 8'($urandom_range(0, 1));
				issue_op(hct_pkg::FUNC_WRITE, 8'($urandom), addr, data);
			end else begin
				issue_op(hct_pkg::FUNC_NONE, 8'($urandom), 16'($urandom), 8'($urandom));
			end
		end
		in_valid <= 1'b0;

		// Let the last acceptance register, drain, then allow for any
		// trailing activity before the verdict.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d ticks, %0d reads, %0d writes and %0d unused-code items.",
			func_count[hct_pkg::FUNC_TICK], func_count[hct_pkg::FUNC_READ],
			func_count[hct_pkg::FUNC_WRITE], func_count[hct_pkg::FUNC_NONE]);
		$display("Checked %0d results, %0d of them with the timer interrupt raised.",
			results_seen, irqs_seen);
		if (fails == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Watchdog: the slowest legal run is far shorter than this.
	initial begin
		#5_000_000;
		$display("Timeout with %0d results still outstanding.", pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
sv/hct_pkg.sv
sv/hct_ctrl.sv
sv/hct_dp.sv
sv/handheld_console_timer.sv
tb/timer_checker.sv
tb/tb.sv
